### rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

### rtl/sst_pkg.sv
package sst_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_FULL      = 3'd4,
    ST_ENTRY     = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DUMP,
    S_FINISH
  } state_t;

endpackage

### rtl/sorted_set_table_unit.sv
// Insert/delete: one memory read per entry walked, then one result; insert exits early
// on a duplicate or on a larger entry when full, delete exits early on a larger entry.
// Dump: one entry per cycle while rsp is not stalled; an empty table gives one result.
// One item in flight at a time.
// Reset clears count and control state; the entry memory is not cleared.
`include "assert_macros.svh"

module sorted_set_table_unit
  import sst_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         op,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] value_out,
  output logic [2:0]         status,
  output logic               last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // entry store, one synchronous read port and one write port
  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] mem_rdata;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next, idx_inc;
  logic [1:0]         op_r, op_next;
  logic signed [31:0] val_r, val_next;
  logic signed [31:0] carry, carry_next;
  logic               placed, placed_next;
  status_t            res_status, res_next;
  logic               rsp_valid_next;

  logic               req_fire;
  logic               rsp_free;
  logic               scan_done;
  logic               dump_last;
  logic               full;
  logic               rsp_load;
  logic signed [31:0] rsp_value;
  status_t            rsp_status;
  logic               rsp_last;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign idx_inc   = idx + CW'(1);
  assign dump_last = (idx_inc == count);
  assign full      = (count == CW'(CAPACITY));

  // datapath control
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = idx[AW-1:0];
    mem_wdata   = val_r;
    rd_en       = 1'b0;
    rd_addr     = idx_inc[AW-1:0];
    idx_next    = idx;
    carry_next  = carry;
    placed_next = placed;
    count_next  = count;
    res_next    = res_status;
    op_next     = op_r;
    val_next    = val_r;
    scan_done   = 1'b0;
    rsp_load    = 1'b0;
    rsp_value   = val_r;
    rsp_status  = res_status;
    rsp_last    = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          op_next     = op;
          val_next    = (op == OP_DUMP) ? 32'sd0 : value;
          idx_next    = '0;
          placed_next = 1'b0;
          rd_en       = 1'b1;
          rd_addr     = '0;
          res_next    = ST_EMPTY;
        end
      end
      S_SCAN: begin
        if (op_r == OP_INSERT) begin
          // placed: v is written, later entries ripple up by one slot
          if (idx == count) begin
            scan_done = 1'b1;
            if (placed) begin
              mem_we     = 1'b1;
              mem_wdata  = carry;
              count_next = count + CW'(1);
              res_next   = ST_INSERTED;
            end else if (full) begin
              res_next = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              count_next = count + CW'(1);
              res_next   = ST_INSERTED;
            end
          end else if (placed) begin
            mem_we     = 1'b1;
            mem_wdata  = carry;
            carry_next = mem_rdata;
          end else if (mem_rdata == val_r) begin
            scan_done = 1'b1;
            res_next  = ST_DUPLICATE;
          end else if (mem_rdata > val_r) begin
            if (full) begin
              scan_done = 1'b1;
              res_next  = ST_FULL;
            end else begin
              mem_we      = 1'b1;
              carry_next  = mem_rdata;
              placed_next = 1'b1;
            end
          end
        end else begin
          // placed: match found, later entries move down by one slot
          if (idx == count) begin
            scan_done = 1'b1;
            if (placed) begin
              count_next = count - CW'(1);
              res_next   = ST_DELETED;
            end else begin
              res_next = ST_NOTFOUND;
            end
          end else if (placed) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(idx - CW'(1));
            mem_wdata = mem_rdata;
          end else if (mem_rdata == val_r) begin
            placed_next = 1'b1;
          end else if (mem_rdata > val_r) begin
            scan_done = 1'b1;
            res_next  = ST_NOTFOUND;
          end
        end
        if (!scan_done) begin
          rd_en    = 1'b1;
          idx_next = idx_inc;
        end
      end
      S_DUMP: begin
        if (rsp_free) begin
          rsp_load   = 1'b1;
          rsp_value  = mem_rdata;
          rsp_status = ST_ENTRY;
          rsp_last   = dump_last;
          rd_en      = 1'b1;
          idx_next   = idx_inc;
        end
      end
      S_FINISH: begin
        if (rsp_free) begin
          rsp_load = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rsp_valid_next = rsp_load || (rsp_valid && rsp_stall);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          priority if (op == OP_INSERT || op == OP_DELETE) begin
            state_next = S_SCAN;
          end else if (op == OP_DUMP) begin
            state_next = (count == '0) ? S_FINISH : S_DUMP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_DUMP: begin
        if (rsp_free && dump_last) begin
          state_next = S_IDLE;
        end
      end
      S_FINISH: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    op_r       <= op_next;
    val_r      <= val_next;
    carry      <= carry_next;
    placed     <= placed_next;
    res_status <= res_next;
    if (rsp_load) begin
      value_out <= rsp_value;
      status    <= rsp_status;
      last      <= rsp_last;
    end
  end

  // writes and reads never hit the same entry in one cycle: the walk writes behind
  // the read pointer, and a new item reads only after the previous one finished
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_rdata <= mem[rd_addr];
    end
  end

  `ASSERT_CLK(a_count_bound, count <= CW'(CAPACITY), "count above capacity")
  `ASSERT_CLK(a_we_in_scan, mem_we |-> (state == S_SCAN), "memory write outside scan")
  `ASSERT_CLK(a_count_step, (count != $past(count)) |-> $past(scan_done), "stray count update")
  `ASSERT_NEVER(a_load_busy, rsp_load && rsp_valid && rsp_stall, "result overwritten while stalled")

endmodule
